/* sv/elrc_pkg.sv */
// ---------------------------------------------------------------------------
// elrc_pkg
// Shared types and constants for the encoder lap reward controller.
// ---------------------------------------------------------------------------
package elrc_pkg;

	localparam int STEP_BITS_DEF = 24;
	localparam int LAP_BITS_DEF  = 16;

	localparam int MIN_W        = 23;
	localparam int NEG_W        = 24;
	localparam int PULSE_W      = 16;
	localparam int CFG_DATA_W   = 24;
	localparam int CFG_INDEX_W  = 2;
	localparam int AGE_W        = 17;

	localparam logic [AGE_W-1:0]   AGE_MAX       = 17'd65536;
	localparam logic [MIN_W-1:0]   MIN_STEPS_RST = 23'd10000;
	localparam logic [NEG_W-1:0]   NEG_STEPS_RST = 24'hFFFC18;  // -1000
	localparam logic [PULSE_W-1:0] PULSE_MS_RST  = 16'd50;

	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEPS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEG_STEPS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_MS  = 2'd2;

	typedef enum logic [1:0] {
		REQ_ENC   = 2'd0,
		REQ_PHOTO = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	typedef struct packed {
		logic [MIN_W-1:0]   min_steps;
		logic [NEG_W-1:0]   neg_steps;
		logic [PULSE_W-1:0] pulse_ms;
	} cfg_t;

	typedef struct packed {
		logic reward;
		logic photo;
		logic lap_done;
		logic cleared;
	} flags_t;

endpackage

/* sv/elrc_cfg.sv */
// ---------------------------------------------------------------------------
// elrc_cfg
// Configuration register file: threshold and pulse length registers.
// ---------------------------------------------------------------------------
module elrc_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [elrc_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [elrc_pkg::CFG_DATA_W-1:0]      wr_data,
	output elrc_pkg::cfg_t                       cfg
);

	elrc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_steps <= elrc_pkg::MIN_STEPS_RST;
			cfg_q.neg_steps <= elrc_pkg::NEG_STEPS_RST;
			cfg_q.pulse_ms  <= elrc_pkg::PULSE_MS_RST;
		end else if (wr_en) begin
			case (wr_index)
				elrc_pkg::CFG_MIN_STEPS: begin
					cfg_q.min_steps <= wr_data[elrc_pkg::MIN_W-1:0];
				end
				elrc_pkg::CFG_NEG_STEPS: begin
					cfg_q.neg_steps <= wr_data[elrc_pkg::NEG_W-1:0];
				end
				elrc_pkg::CFG_PULSE_MS: begin
					cfg_q.pulse_ms <= wr_data[elrc_pkg::PULSE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/elrc_core.sv */
// ---------------------------------------------------------------------------
// elrc_core
// Step, lap and pulse state with its combinational next-state logic.
// ---------------------------------------------------------------------------
module elrc_core #(
	parameter int STEP_BITS = elrc_pkg::STEP_BITS_DEF,
	parameter int LAP_BITS  = elrc_pkg::LAP_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [1:0]                  req_type,
	input  logic                        a_level,
	input  logic                        b_level,
	input  elrc_pkg::cfg_t              cfg,
	output elrc_pkg::flags_t            flags_nxt,
	output logic signed [STEP_BITS-1:0] step_nxt,
	output logic [LAP_BITS-1:0]         lap_nxt
);

	localparam int CMP_W = ((STEP_BITS > elrc_pkg::NEG_W) ? STEP_BITS : elrc_pkg::NEG_W) + 1;
	localparam logic [STEP_BITS-1:0] STEP_MAX = {1'b0, {(STEP_BITS-1){1'b1}}};
	localparam logic [STEP_BITS-1:0] STEP_MIN = {1'b1, {(STEP_BITS-1){1'b0}}};

	logic signed [STEP_BITS-1:0]  step_q;
	logic [LAP_BITS-1:0]          lap_q;
	logic [elrc_pkg::AGE_W-1:0]   reward_age_q;
	logic [elrc_pkg::AGE_W-1:0]   photo_age_q;
	logic                         reward_lvl_q;
	logic                         photo_lvl_q;

	logic [elrc_pkg::AGE_W-1:0]   reward_age_nxt;
	logic [elrc_pkg::AGE_W-1:0]   photo_age_nxt;
	logic [elrc_pkg::AGE_W-1:0]   reward_age_inc;
	logic [elrc_pkg::AGE_W-1:0]   photo_age_inc;
	logic [elrc_pkg::AGE_W-1:0]   pulse_ext;
	logic signed [CMP_W-1:0]      step_ext;
	logic signed [CMP_W-1:0]      min_ext;
	logic signed [CMP_W-1:0]      neg_ext;

	assign step_ext  = CMP_W'(step_q);
	assign min_ext   = $signed({{(CMP_W-elrc_pkg::MIN_W){1'b0}}, cfg.min_steps});
	assign neg_ext   = $signed({{(CMP_W-elrc_pkg::NEG_W){cfg.neg_steps[elrc_pkg::NEG_W-1]}},
		cfg.neg_steps});
	assign pulse_ext = {1'b0, cfg.pulse_ms};

	assign reward_age_inc = (reward_age_q >= elrc_pkg::AGE_MAX) ? elrc_pkg::AGE_MAX
		: reward_age_q + 1'b1;
	assign photo_age_inc  = (photo_age_q >= elrc_pkg::AGE_MAX) ? elrc_pkg::AGE_MAX
		: photo_age_q + 1'b1;

	always_comb begin
		step_nxt           = step_q;
		lap_nxt            = lap_q;
		reward_age_nxt     = reward_age_q;
		photo_age_nxt      = photo_age_q;
		flags_nxt.reward   = reward_lvl_q;
		flags_nxt.photo    = photo_lvl_q;
		flags_nxt.lap_done = 1'b0;
		flags_nxt.cleared  = 1'b0;
		case (elrc_pkg::req_t'(req_type))
			elrc_pkg::REQ_ENC: begin
				if (a_level == b_level) begin
					if (step_q != $signed(STEP_MAX))
						step_nxt = step_q + 1'b1;
				end else begin
					if (step_q != $signed(STEP_MIN))
						step_nxt = step_q - 1'b1;
				end
			end
			elrc_pkg::REQ_PHOTO: begin
				flags_nxt.photo = 1'b1;
				photo_age_nxt   = '0;
				if (step_ext > min_ext) begin
					flags_nxt.reward   = 1'b1;
					reward_age_nxt     = '0;
					step_nxt           = '0;
					lap_nxt            = lap_q + 1'b1;
					flags_nxt.lap_done = 1'b1;
				end
			end
			elrc_pkg::REQ_TICK: begin
				reward_age_nxt = reward_age_inc;
				photo_age_nxt  = photo_age_inc;
				if (reward_age_inc > pulse_ext)
					flags_nxt.reward = 1'b0;
				if (photo_age_inc > pulse_ext)
					flags_nxt.photo = 1'b0;
				if (step_ext < neg_ext) begin
					step_nxt          = '0;
					flags_nxt.cleared = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			lap_q        <= '0;
			reward_age_q <= elrc_pkg::AGE_MAX;
			photo_age_q  <= elrc_pkg::AGE_MAX;
			reward_lvl_q <= 1'b0;
			photo_lvl_q  <= 1'b0;
		end else if (accept) begin
			step_q       <= step_nxt;
			lap_q        <= lap_nxt;
			reward_age_q <= reward_age_nxt;
			photo_age_q  <= photo_age_nxt;
			reward_lvl_q <= flags_nxt.reward;
			photo_lvl_q  <= flags_nxt.photo;
		end
	end

endmodule

/* sv/encoder_lap_reward_controller_unit.sv */
// Takes one event per cycle (encoder edge, photo edge or millisecond tick)
// and returns one result transaction per event in the cycle after acceptance.
// All state updates complete in the accepting cycle, so a new event can be
// taken every cycle; throughput drops only while the result register holds
// a stalled transaction. Configuration writes are always ready.
// ---------------------------------------------------------------------------
// encoder_lap_reward_controller_unit
// Encoder step counter with lap reward and pulse timing, result register.
// ---------------------------------------------------------------------------
module encoder_lap_reward_controller_unit #(
	parameter int STEP_BITS = elrc_pkg::STEP_BITS_DEF,
	parameter int LAP_BITS  = elrc_pkg::LAP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [elrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [elrc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       req_type,
	input  logic                             a_level,
	input  logic                             b_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             reward_out,
	output logic                             photo_fwd_out,
	output logic                             lap_done,
	output logic                             distance_cleared,
	output logic signed [STEP_BITS-1:0]      step_total,
	output logic [LAP_BITS-1:0]              lap_total
);

	elrc_pkg::cfg_t              cfg;
	elrc_pkg::flags_t            flags_nxt;
	elrc_pkg::flags_t            flags_q;
	logic signed [STEP_BITS-1:0] step_nxt;
	logic signed [STEP_BITS-1:0] step_q;
	logic [LAP_BITS-1:0]         lap_nxt;
	logic [LAP_BITS-1:0]         lap_q;
	logic                        out_valid_q;
	logic                        accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;

	elrc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	elrc_core #(
		.STEP_BITS (STEP_BITS),
		.LAP_BITS  (LAP_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.a_level   (a_level),
		.b_level   (b_level),
		.cfg       (cfg),
		.flags_nxt (flags_nxt),
		.step_nxt  (step_nxt),
		.lap_nxt   (lap_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_q <= flags_nxt;
			step_q  <= step_nxt;
			lap_q   <= lap_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign reward_out       = flags_q.reward;
	assign photo_fwd_out    = flags_q.photo;
	assign lap_done         = flags_q.lap_done;
	assign distance_cleared = flags_q.cleared;
	assign step_total       = step_q;
	assign lap_total        = lap_q;

endmodule

/* bench/encoder_lap_reward_controller_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_lap_reward_controller_unit_tb
// Self-checking bench for the lap reward controller. Events are driven
// through the valid/stall input port with random gaps, results are taken
// with random back-pressure, and a scoreboard holding a mirror of the step,
// lap and pulse state checks every result transaction in order. Covers
// directed corner cases and random phases over several register settings.
// ---------------------------------------------------------------------------
module encoder_lap_reward_controller_unit_tb;

	localparam int STEP_W     = elrc_pkg::STEP_BITS_DEF;
	localparam int LAP_W      = elrc_pkg::LAP_BITS_DEF;
	localparam int DATA_W     = elrc_pkg::CFG_DATA_W;
	localparam int INDEX_W    = elrc_pkg::CFG_INDEX_W;
	localparam int MIN_BITS   = elrc_pkg::MIN_W;
	localparam int NEG_BITS   = elrc_pkg::NEG_W;
	localparam int PULSE_BITS = elrc_pkg::PULSE_W;
	localparam int PULSE_PAD  = DATA_W - PULSE_BITS;
	localparam int AGE_TOP    = elrc_pkg::AGE_MAX;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int STEP_HI = 2**(STEP_W-1) - 1;
	localparam int STEP_LO = -(2**(STEP_W-1));
	localparam int MIN_STEPS_TOP = 2**MIN_BITS - 1;
	localparam int PULSE_MS_TOP = 2**PULSE_BITS - 1;
	localparam logic [DATA_W-1:0] NEG_FLOOR_WORD = {1'b1, {(NEG_BITS-1){1'b0}}};
	localparam logic [DATA_W-1:0] NEG_ONE_WORD = {DATA_W{1'b1}};

	typedef struct {
		elrc_pkg::flags_t         flags;
		logic signed [STEP_W-1:0] steps;
		logic [LAP_W-1:0]         laps;
	} status_t;

	class lap_reward_scoreboard;
		int               step_count;
		logic [LAP_W-1:0] lap_count;
		int               reward_age;
		int               photo_age;
		bit               reward_on;
		bit               photo_on;
		int               min_steps;
		int               neg_steps;
		int               pulse_ms;
		status_t          pending_status[$];
		int               mismatches;
		int               checked;
		int               laps_granted;
		int               clears_seen;

		function void power_on();
			step_count = 0;
			lap_count  = '0;
			reward_age = AGE_TOP;
			photo_age  = AGE_TOP;
			reward_on  = 1'b0;
			photo_on   = 1'b0;
			min_steps  = elrc_pkg::MIN_STEPS_RST;
			neg_steps  = $signed(elrc_pkg::NEG_STEPS_RST);
			pulse_ms   = elrc_pkg::PULSE_MS_RST;
		endfunction

		function void set_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				elrc_pkg::CFG_MIN_STEPS: min_steps = data[MIN_BITS-1:0];
				elrc_pkg::CFG_NEG_STEPS: neg_steps = $signed(data[NEG_BITS-1:0]);
				elrc_pkg::CFG_PULSE_MS:  pulse_ms = data[PULSE_BITS-1:0];
				default: ;
			endcase
		endfunction

		// advance the mirrored controller by one accepted event
		function void note_event(logic [1:0] kind, logic a, logic b);
			status_t st;
			st.flags = '0;
			case (kind)
				elrc_pkg::REQ_ENC: begin
					if (a == b) begin
						if (step_count < STEP_HI)
							step_count++;
					end else if (step_count > STEP_LO) begin
						step_count--;
					end
				end
				elrc_pkg::REQ_PHOTO: begin
					photo_on  = 1'b1;
					photo_age = 0;
					if (step_count > min_steps) begin
						reward_on  = 1'b1;
						reward_age = 0;
						step_count = 0;
						lap_count++;
						st.flags.lap_done = 1'b1;
					end
				end
				elrc_pkg::REQ_TICK: begin
					reward_age = (reward_age >= AGE_TOP) ? AGE_TOP : reward_age + 1;
					photo_age  = (photo_age >= AGE_TOP) ? AGE_TOP : photo_age + 1;
					if (reward_age > pulse_ms)
						reward_on = 1'b0;
					if (photo_age > pulse_ms)
						photo_on = 1'b0;
					if (step_count < neg_steps) begin
						step_count = 0;
						st.flags.cleared = 1'b1;
					end
				end
				default: ;
			endcase
			st.flags.reward = reward_on;
			st.flags.photo  = photo_on;
			st.steps        = step_count[STEP_W-1:0];
			st.laps         = lap_count;
			pending_status.push_back(st);
		endfunction

		function void check_status(elrc_pkg::flags_t f, logic signed [STEP_W-1:0] steps,
				logic [LAP_W-1:0] laps);
			status_t want;
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no event pending: flags=%b steps=%0d laps=%0d",
						$time, f, steps, laps);
				return;
			end
			want = pending_status.pop_front();
			checked++;
			if (want.flags.lap_done)
				laps_granted++;
			if (want.flags.cleared)
				clears_seen++;
			if (f !== want.flags || steps !== want.steps || laps !== want.laps) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch: expected reward=%0b photo=%0b lap=%0b clr=%0b steps=%0d laps=%0d",
						$time, want.flags.reward, want.flags.photo, want.flags.lap_done,
						want.flags.cleared, want.steps, want.laps);
					$display("%0t: mismatch: got      reward=%0b photo=%0b lap=%0b clr=%0b steps=%0d laps=%0d",
						$time, f.reward, f.photo, f.lap_done, f.cleared, steps, laps);
				end
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [INDEX_W-1:0]       cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               req_type = '0;
	logic                     a_level = 1'b0;
	logic                     b_level = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     reward_out;
	logic                     photo_fwd_out;
	logic                     lap_done;
	logic                     distance_cleared;
	logic signed [STEP_W-1:0] step_total;
	logic [LAP_W-1:0]         lap_total;

	bit                   idle_en = 1'b1;
	int unsigned          stall_left = 0;
	int                   events_sent = 0;
	int                   config_loads = 0;
	lap_reward_scoreboard mirror = new();

	encoder_lap_reward_controller_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.a_level          (a_level),
		.b_level          (b_level),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.reward_out       (reward_out),
		.photo_fwd_out    (photo_fwd_out),
		.lap_done         (lap_done),
		.distance_cleared (distance_cleared),
		.step_total       (step_total),
		.lap_total        (lap_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check each transaction, then hold off for a random count
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			mirror.check_status({reward_out, photo_fwd_out, lap_done, distance_cleared},
				step_total, lap_total);
			stall_left = idle_en ? $urandom_range(0, 7) : 0;
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_event(logic [1:0] kind, logic a, logic b);
		int unsigned gap;
		gap = idle_en ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		a_level  <= a;
		b_level  <= b;
		do @(posedge clk); while (in_stall);
		mirror.note_event(kind, a, b);
		events_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.pending_status.size() != 0);
	endtask

	task automatic load_config(logic [DATA_W-1:0] min_v, logic [DATA_W-1:0] neg_v,
			logic [DATA_W-1:0] pulse_v);
		logic [DATA_W-1:0]  vals [3];
		logic [INDEX_W-1:0] regs [3];
		vals = '{min_v, neg_v, pulse_v};
		regs = '{elrc_pkg::CFG_MIN_STEPS, elrc_pkg::CFG_NEG_STEPS, elrc_pkg::CFG_PULSE_MS};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			mirror.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		config_loads++;
	endtask

	// small thresholds most of the time so laps and clears happen often
	task automatic random_config();
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] n;
		logic [DATA_W-1:0] p;
		int unsigned       pick;
		m = DATA_W'($urandom_range(0, 30));
		n = DATA_W'(0 - int'($urandom_range(0, 30)));
		p = DATA_W'($urandom_range(0, 8));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			m = DATA_W'(MIN_STEPS_TOP);
		else if (pick == 1)
			m[MIN_BITS-1:0] = MIN_BITS'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			n = NEG_FLOOR_WORD;
		else if (pick == 1)
			n = '0;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			p = DATA_W'(PULSE_MS_TOP);
		else if (pick == 1)
			p = DATA_W'($urandom_range(0, PULSE_MS_TOP));
		m[DATA_W-1] = 1'($urandom_range(0, 1));
		p[DATA_W-1:PULSE_BITS] = PULSE_PAD'($urandom);
		load_config(m, n, p);
	endtask

	task automatic random_phase(int count, int fwd_pct, bit with_pause);
		int unsigned roll;
		logic        a;
		logic        fwd;
		for (int i = 0; i < count; i++) begin
			if (with_pause && i == count / 2)
				drain();
			roll = $urandom_range(0, 99);
			a = 1'($urandom_range(0, 1));
			if (roll < 55) begin
				fwd = ($urandom_range(0, 99) < fwd_pct);
				send_event(elrc_pkg::REQ_ENC, a, fwd ? a : !a);
			end else if (roll < 70) begin
				send_event(elrc_pkg::REQ_PHOTO, a, 1'($urandom_range(0, 1)));
			end else if (roll < 95) begin
				send_event(elrc_pkg::REQ_TICK, a, 1'($urandom_range(0, 1)));
			end else begin
				send_event(REQ_SPARE, a, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		int fwd_mix [4];
		fwd_mix = '{80, 50, 20, 95};
		mirror.power_on();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: unused code, all four encoder level pairs, photo below threshold
		send_event(REQ_SPARE, 1'b1, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b1, 1'b1);
		send_event(elrc_pkg::REQ_ENC, 1'b0, 1'b1);
		send_event(elrc_pkg::REQ_ENC, 1'b1, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b1, 1'b1);
		send_event(elrc_pkg::REQ_PHOTO, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_TICK, 1'b0, 1'b0);
		drain();

		// lap at zero threshold, count equal to threshold, pulse edge, clear boundary
		load_config('0, NEG_ONE_WORD, DATA_W'(2));
		send_event(elrc_pkg::REQ_PHOTO, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_PHOTO, 1'b1, 1'b1);
		send_event(elrc_pkg::REQ_TICK, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_TICK, 1'b1, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b0, 1'b1);
		send_event(elrc_pkg::REQ_TICK, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b1, 1'b0);
		send_event(elrc_pkg::REQ_TICK, 1'b0, 1'b1);
		send_event(REQ_SPARE, 1'b0, 1'b1);
		drain();

		// extreme registers: no lap possible, zero-length pulse, no clear
		load_config(DATA_W'(MIN_STEPS_TOP), NEG_FLOOR_WORD, '0);
		send_event(elrc_pkg::REQ_ENC, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_PHOTO, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_TICK, 1'b0, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b0, 1'b1);
		send_event(elrc_pkg::REQ_ENC, 1'b1, 1'b0);
		send_event(elrc_pkg::REQ_ENC, 1'b0, 1'b1);
		send_event(elrc_pkg::REQ_TICK, 1'b1, 1'b1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			idle_en = (ph % 3 != 2);
			random_phase(200, fwd_mix[ph % 4], ph == 1);
			drain();
		end

		idle_en = 1'b1;
		random_config();
		random_phase(120, 60, 1'b0);
		drain();
		repeat (4) @(posedge clk);

		$display("run: %0d events, %0d results checked, %0d mismatches, %0d config loads",
			events_sent, mirror.checked, mirror.mismatches, config_loads);
		$display("seen: %0d lap rewards, %0d distance clears, spare codes and saturated ages",
			mirror.laps_granted, mirror.clears_seen);
		if (mirror.mismatches == 0 && mirror.pending_status.size() == 0) begin
			$display("encoder_lap_reward_controller_unit_tb: clean");
		end else begin
			$display("encoder_lap_reward_controller_unit_tb: errors");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d results outstanding", mirror.pending_status.size());
		$display("encoder_lap_reward_controller_unit_tb: errors");
		$finish;
	end

endmodule
